// File: sv/stl_pkg.sv
`default_nettype none

package stl_pkg;

  localparam int unsigned MAX_RUN_DEF = 255;
  // Run count is compared against 255 at this width for any MAX_RUN up to 65535
  localparam int RUN_EXT_W = 17;

  localparam logic [7:0] CH_DASH = "-";

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       starts_query;
  } stl_in_t;

  typedef struct packed {
    logic [7:0] token_length;
    logic       split_into_pieces;
    logic       run_saturated;
  } stl_out_t;

  function automatic logic is_symbol_char(input logic [7:0] c);
    case (c)
      "!", "$", "%", "&", "(", ")", "*", "+", ",", "-", ".", "/", ":", ";",
      "<", "=", ">", "?", "[", "]", "\\", "_", "{", "}", "|", "~": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic elem1(input logic [7:0] a);
    case (a)
      "&", "(", ")", ",", ".", ":", "=", ">", "[", "]", "_", "{", "}", "|": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic elem2(input logic [7:0] a, input logic [7:0] b);
    return (a == "&" && (b == "!" || b == "?")) ||
           (a == "-" && b == ">") || (a == "." && b == ".") ||
           (a == ":" && b == ":") || (a == "=" && b == ">") ||
           (a == "_" && b == "_");
  endfunction

  function automatic logic elem3(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
    return a == "." && b == "." && c == ".";
  endfunction

endpackage

`default_nettype wire

// File: sv/symbol_token_length_top.sv
// Symbol token length measurement.
// Input channel (in_valid/in_ready/in_data) carries one text item per
// handshake: a character or an end-of-text mark, with starts_query set on
// the item at the query position. Items outside an active query are dropped.
// When the run of symbol characters ends (non-symbol character or end of
// text) one result item is sent on the output channel (out_valid/out_ready/
// out_data): the first elementary piece length if the run splits fully,
// else the run length clamped to 255, plus split and saturation flags.
// A result is registered: its input item is taken into the input register, then
// the result into the result register. Throughput: one item per cycle while the
// output is not stalled; per-item work is a 3-character window match and a run count.
// Reset (rst_n low, synchronous) empties both registers and ends any query.
// While the receiver stalls, the pending result holds; one more item can sit
// in the input register, after which in_ready drops until out_ready returns.
`default_nettype none

module symbol_token_length_top #(
  parameter int unsigned MAX_RUN = stl_pkg::MAX_RUN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire stl_pkg::stl_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output stl_pkg::stl_out_t     out_data
);
  import stl_pkg::*;

  localparam int RCW = $clog2(MAX_RUN + 1);
  localparam logic [7:0] SAT_LEN = (MAX_RUN > 255) ? 8'd255 : 8'(MAX_RUN);

  logic           in_vld_r;
  stl_in_t        in_r;
  logic           out_vld_r;
  stl_out_t       out_r;

  logic           act_r, act_nxt;
  logic [RCW-1:0] rc_r, rc_nxt;
  logic [7:0]     w0_r, w0_nxt, w1_r, w1_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           ok_r, ok_nxt;
  logic [1:0]     fpl_r, fpl_nxt;
  logic           fpk_r, fpk_nxt;
  logic           ovf_r, ovf_nxt;

  logic           out_free, advance, produce;
  stl_out_t       res;

  assign out_free  = !out_vld_r || out_ready;
  assign advance   = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    logic                 act_e, ok_e, fpk_e, ovf_e, is_end, gt1;
    logic [RCW-1:0]       rc_e;
    logic [1:0]           fill_e, fpl_e;
    logic [RUN_EXT_W-1:0] rc_x;
    logic [1:0]           p, f, l;
    logic                 s, k;
    logic [7:0]           a, b;

    act_e  = act_r;
    rc_e   = rc_r;
    fill_e = fill_r;
    ok_e   = ok_r;
    fpl_e  = fpl_r;
    fpk_e  = fpk_r;
    ovf_e  = ovf_r;
    if (in_r.starts_query) begin
      act_e  = 1'b1;
      rc_e   = '0;
      fill_e = 2'd0;
      ok_e   = 1'b1;
      fpl_e  = 2'd0;
      fpk_e  = 1'b0;
      ovf_e  = 1'b0;
    end
    is_end = in_r.kind || !is_symbol_char(in_r.ch);
    rc_x   = RUN_EXT_W'(rc_e);
    gt1    = rc_x > RUN_EXT_W'(1);

    act_nxt  = act_e;
    rc_nxt   = rc_e;
    w0_nxt   = w0_r;
    w1_nxt   = w1_r;
    fill_nxt = fill_e;
    ok_nxt   = ok_e;
    fpl_nxt  = fpl_e;
    fpk_nxt  = fpk_e;
    ovf_nxt  = ovf_e;
    produce  = 1'b0;
    p        = 2'd0;

    // finish: at most two pieces remain in the window
    f = fill_e;
    s = ok_e;
    k = fpk_e;
    l = fpl_e;
    a = w0_r;
    b = w1_r;
    if (f != 2'd0 && s) begin
      if (f == 2'd1 && a == CH_DASH && gt1) begin
        f = 2'd0;
      end else begin
        if (f == 2'd2 && elem2(a, b)) p = 2'd2;
        else if (elem1(a))            p = 2'd1;
        else                          p = 2'd0;
        if (p == 2'd0) begin
          s = 1'b0;
          f = 2'd0;
        end else begin
          if (!k) begin
            k = 1'b1;
            l = p;
          end
          if (p == 2'd2) begin
            f = 2'd0;
          end else begin
            f = f - 2'd1;
            a = b;
          end
        end
      end
    end
    if (f != 2'd0 && s) begin
      if (a == CH_DASH && gt1) begin
        f = 2'd0;
      end else if (elem1(a)) begin
        if (!k) begin
          k = 1'b1;
          l = 2'd1;
        end
        f = 2'd0;
      end else begin
        s = 1'b0;
      end
    end

    if (rc_x == '0) begin
      res.token_length      = 8'd0;
      res.split_into_pieces = 1'b0;
    end else if (s && k) begin
      res.token_length      = {6'd0, l};
      res.split_into_pieces = 1'b1;
    end else begin
      res.token_length      = (rc_x > RUN_EXT_W'(255)) ? 8'd255 : rc_x[7:0];
      res.split_into_pieces = 1'b0;
    end
    res.run_saturated = ovf_e || (rc_x > RUN_EXT_W'(255));

    if (act_e) begin
      if (is_end) begin
        produce = 1'b1;
        act_nxt = 1'b0;
      end else begin
        if (rc_e < RCW'(MAX_RUN)) rc_nxt = rc_e + 1'b1;
        else                      ovf_nxt = 1'b1;
        if (ok_e) begin
          case (fill_e)
            2'd0: begin
              w0_nxt   = in_r.ch;
              fill_nxt = 2'd1;
            end
            2'd1: begin
              w1_nxt   = in_r.ch;
              fill_nxt = 2'd2;
            end
            default: begin
              if (elem3(w0_r, w1_r, in_r.ch)) p = 2'd3;
              else if (elem2(w0_r, w1_r))     p = 2'd2;
              else if (elem1(w0_r))           p = 2'd1;
              else                            p = 2'd0;
              case (p)
                2'd3: fill_nxt = 2'd0;
                2'd2: begin
                  w0_nxt   = in_r.ch;
                  fill_nxt = 2'd1;
                end
                2'd1: begin
                  w0_nxt   = w1_r;
                  w1_nxt   = in_r.ch;
                  fill_nxt = 2'd2;
                end
                default: begin
                  ok_nxt   = 1'b0;
                  fill_nxt = 2'd0;
                end
              endcase
              if (p != 2'd0 && !fpk_e) begin
                fpk_nxt = 1'b1;
                fpl_nxt = p;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      act_r     <= 1'b0;
      rc_r      <= '0;
      fill_r    <= 2'd0;
      ok_r      <= 1'b1;
      fpl_r     <= 2'd0;
      fpk_r     <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        act_r  <= act_nxt;
        rc_r   <= rc_nxt;
        fill_r <= fill_nxt;
        ok_r   <= ok_nxt;
        fpl_r  <= fpl_nxt;
        fpk_r  <= fpk_nxt;
        ovf_r  <= ovf_nxt;
      end
      if (advance && produce) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (advance) begin
      w0_r <= w0_nxt;
      w1_r <= w1_nxt;
    end
    if (advance && produce) begin
      out_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_split_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.split_into_pieces |->
      out_r.token_length != 8'd0 && out_r.token_length <= 8'd3)
    else $error("split result with bad piece length");

  a_sat_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.run_saturated && !out_r.split_into_pieces |->
      out_r.token_length == SAT_LEN)
    else $error("saturated run not clamped");

  a_unsplit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ok_r |-> fill_r == 2'd0)
    else $error("window holds chars after split failed");

  a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    RUN_EXT_W'(rc_r) <= RUN_EXT_W'(MAX_RUN) && fill_r != 2'd3)
    else $error("run count or window fill out of range");
`endif

endmodule

`default_nettype wire
